// File: sv/sktab_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Field widths, operation and status codes, and the request and response
// types shared by the sorted key table modules.
// ----------------------------------------------------------------------------
package sktab_pkg;

    localparam int unsigned OP_W         = 2;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned ST_W         = 2;
    localparam int unsigned POS_W        = 7;
    localparam int unsigned ENTRY_W      = KEY_W + VAL_W;
    localparam int unsigned CAPACITY_DEF = 64;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] found_value;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entries_used;
    } t_rsp;

endpackage

// File: sv/sktab_mem.sv
// ----------------------------------------------------------------------------
// Sorted key table entry memory
// Single write port, single read port, registered read data. Each word holds
// a key in its upper half and the paired handle in its lower half.
// ----------------------------------------------------------------------------
module sktab_mem #(
    parameter int unsigned DEPTH = sktab_pkg::CAPACITY_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [sktab_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [sktab_pkg::ENTRY_W-1:0] o_rdata
);
    import sktab_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key table unit
// Key/handle table kept in ascending key order, served by insert, remove and
// lookup requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time by a sequencer around an entry memory
// with one write port, one read port and registered read data. A lookup
// takes the request, runs a binary search in which each step reads the
// middle entry and then compares it, reads and checks the found slot, and
// hands over the response. An insert then moves each entry above the slot up
// by a read and a write and stores the new pair; a remove moves each entry
// above the slot down the same way. A new request is taken while the
// previous response still waits to be collected.
// ----------------------------------------------------------------------------
module sorted_key_table_unit #(
    parameter int unsigned CAPACITY = sktab_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  sktab_pkg::t_req i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output sktab_pkg::t_rsp o_rsp
);
    import sktab_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_HIT_RD,
        S_HIT_CMP,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic [ST_W-1:0]   r_status, n_status;
    logic [VAL_W-1:0]  r_found, n_found;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic [CW-1:0]      w_mid;
    logic [CW-1:0]      w_idx_dn;
    logic [CW-1:0]      w_idx_up;
    logic               w_hit;
    logic [KEY_W-1:0]   w_rd_key;
    logic [VAL_W-1:0]   w_rd_val;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    sktab_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_rd_key = mem_rdata[ENTRY_W-1:VAL_W];
    assign w_rd_val = mem_rdata[VAL_W-1:0];
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_idx_dn = r_idx - CW'(1);
    assign w_idx_up = r_idx + CW'(1);
    assign w_hit    = (r_lo < r_count) && (w_rd_key == r_key);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_count     = r_count;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = w_mid[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_req.op;
                    n_key   = i_req.key;
                    n_val   = i_req.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_state = S_SRCH_CMP;
                end else begin
                    n_state = S_HIT_RD;
                end
            end
            S_SRCH_CMP: begin
                if (w_rd_key < r_key) begin
                    n_lo = w_mid + CW'(1);
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_SRCH_RD;
            end
            S_HIT_RD: begin
                mem_raddr = r_lo[AW-1:0];
                n_state   = S_HIT_CMP;
            end
            S_HIT_CMP: begin
                n_found = '0;
                n_state = S_DONE;
                if (r_op == OP_INSERT) begin
                    if (w_hit) begin
                        n_status = ST_DUPLICATE;
                    end else if (r_count >= CAP_C) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_OK;
                        n_idx    = r_count;
                        n_state  = S_UP_RD;
                    end
                end else if (r_op == OP_REMOVE) begin
                    if (w_hit) begin
                        n_status = ST_OK;
                        n_found  = w_rd_val;
                        n_idx    = r_lo;
                        n_state  = S_DN_RD;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    if (w_hit) begin
                        n_status = ST_OK;
                        n_found  = w_rd_val;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx > r_lo) begin
                    mem_raddr = w_idx_dn[AW-1:0];
                    n_state   = S_UP_WR;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_lo[AW-1:0];
                    mem_wdata = {r_key, r_val};
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end
            S_UP_WR: begin
                mem_we  = 1'b1;
                n_idx   = w_idx_dn;
                n_state = S_UP_RD;
            end
            S_DN_RD: begin
                if (w_idx_up < r_count) begin
                    mem_raddr = w_idx_up[AW-1:0];
                    n_state   = S_DN_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DN_WR: begin
                mem_we  = 1'b1;
                n_idx   = w_idx_up;
                n_state = S_DN_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.found_value  = r_found;
                    n_out.position     = POS_W'(r_lo);
                    n_out.entries_used = POS_W'(r_count);
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("Entry count exceeds the table capacity.");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UP_RD && r_state != S_DN_RD) |=> $stable(r_count))
        else $error("Entry count changed outside the end of a shift.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_OK) |-> (o_rsp.found_value == '0))
        else $error("Failed request carries a non-zero handle.");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_UP_RD || r_state == S_UP_WR || r_state == S_DN_WR))
        else $error("Memory written outside an insert or remove.");
`endif

endmodule
